// File: design/amq_pkg.sv
// Shared types, constants and the arctangent table of the attitude quaternion block.
package amq_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN = 24;
    localparam int ANG_W = 34;
    localparam int PROD_W = 32;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd1073741824);
    localparam logic signed [ANG_W-1:0] CORDIC_K = ANG_W'(64'sd652032874);
    localparam logic signed [PROD_W-1:0] ONE_Q30 = PROD_W'(64'sd1073741824);

    typedef struct packed {
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } out_item_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic signed [29:0] num_r;
        logic signed [29:0] num_p;
        logic signed [29:0] mag_x;
        logic signed [29:0] mag_y;
        logic               yo;
    } carry_t;

    function automatic logic signed [ANG_W-1:0] atan_bam(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        begin
            case (idx)
                5'd0: v = ANG_W'(536870912);
                5'd1: v = ANG_W'(316933406);
                5'd2: v = ANG_W'(167458907);
                5'd3: v = ANG_W'(85004756);
                5'd4: v = ANG_W'(42667331);
                5'd5: v = ANG_W'(21354465);
                5'd6: v = ANG_W'(10679838);
                5'd7: v = ANG_W'(5340245);
                5'd8: v = ANG_W'(2670163);
                5'd9: v = ANG_W'(1335087);
                5'd10: v = ANG_W'(667544);
                5'd11: v = ANG_W'(333772);
                5'd12: v = ANG_W'(166886);
                5'd13: v = ANG_W'(83443);
                5'd14: v = ANG_W'(41722);
                5'd15: v = ANG_W'(20861);
                5'd16: v = ANG_W'(10430);
                5'd17: v = ANG_W'(5215);
                5'd18: v = ANG_W'(2608);
                5'd19: v = ANG_W'(1304);
                5'd20: v = ANG_W'(652);
                5'd21: v = ANG_W'(326);
                5'd22: v = ANG_W'(163);
                5'd23: v = ANG_W'(81);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: design/accel_mag_attitude_quaternion_top.sv
// Attitude quaternion from one accelerometer and one magnetometer sample, fully pipelined.
//
// An item on the input channel (in_valid/in_ready, in_data) carries acc_x, acc_y, acc_z,
// mag_x and mag_y. Each item gives exactly one quaternion item on the output channel
// (out_valid/out_ready, out_data) in Q1.14, in the order of acceptance.
// The configuration channel (cfg_valid/cfg_ready, cfg_data) writes the yaw-only flag; it is
// always ready and should only be written while no item is in flight.
// An item passes 36 + 2*N register stages, N = min(CORDIC_STEPS, 24): one of squaring, 30 of
// square root (one result bit per stage), one quadrant stage, N vectoring stages, one
// half-angle stage, N rotation stages, two multiply stages and the output register.
// Throughput is one item per cycle while out_ready is high. Every stage carries a valid bit;
// a stage takes a new item whenever it is empty or the stage after it moves, so a stalled
// receiver holds the result in the output register while bubbles further back still fill.
// Reset clears all valid bits and the yaw-only flag; nothing is lost or repeated under stall.
module accel_mag_attitude_quaternion_top
    import amq_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int RT_W = 30;
    localparam int SQ_W = 61;
    localparam int S_SQ = 0;
    localparam int S_RT = 1;
    localparam int S_PRE = S_RT + RT_W;
    localparam int S_VEC = S_PRE + 1;
    localparam int S_ANG = S_VEC + NSTEP;
    localparam int S_ROT = S_ANG + 1;
    localparam int S_MA = S_ROT + NSTEP;
    localparam int S_MB = S_MA + 1;
    localparam int S_OUT = S_MB + 1;
    localparam int NST = S_OUT + 1;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [RT_W-1:0] root;
    } sqs_t;

    function automatic sqs_t sqrt_step(input sqs_t s, input int b);
        sqs_t r;
        logic [SQ_W-1:0] trial;
        begin
            r = s;
            trial = (SQ_W'(s.root) << (b + 1)) + (SQ_W'(1) << (2 * b));
            if (s.rem >= trial)
            begin
                r.rem = s.rem - trial;
                r.root = s.root | (RT_W'(1) << b);
            end
            return r;
        end
    endfunction

    function automatic cordic_t prerot(input logic signed [ANG_W-1:0] y,
                                       input logic signed [ANG_W-1:0] x);
        cordic_t c;
        begin
            c.x = x;
            c.y = y;
            c.z = '0;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    c.x = y;
                    c.y = -x;
                    c.z = QUARTER_TURN;
                end
                else
                begin
                    c.x = -y;
                    c.y = x;
                    c.z = -QUARTER_TURN;
                end
            end
            return c;
        end
    endfunction

    function automatic cordic_t vec_step(input cordic_t c, input int i);
        cordic_t r;
        logic signed [ANG_W-1:0] dx;
        logic signed [ANG_W-1:0] dy;
        begin
            dx = c.y >>> i;
            dy = c.x >>> i;
            if (c.y >= 0)
            begin
                r.x = c.x + dx;
                r.y = c.y - dy;
                r.z = c.z + atan_bam(5'(i));
            end
            else
            begin
                r.x = c.x - dx;
                r.y = c.y + dy;
                r.z = c.z - atan_bam(5'(i));
            end
            return r;
        end
    endfunction

    function automatic cordic_t rot_step(input cordic_t c, input int i);
        cordic_t r;
        logic signed [ANG_W-1:0] dx;
        logic signed [ANG_W-1:0] dy;
        begin
            dx = c.y >>> i;
            dy = c.x >>> i;
            if (c.z >= 0)
            begin
                r.x = c.x - dx;
                r.y = c.y + dy;
                r.z = c.z - atan_bam(5'(i));
            end
            else
            begin
                r.x = c.x + dx;
                r.y = c.y - dy;
                r.z = c.z + atan_bam(5'(i));
            end
            return r;
        end
    endfunction

    function automatic logic signed [PROD_W-1:0] mulq(input logic signed [PROD_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] b);
        logic signed [63:0] p;
        begin
            p = a * b;
            p = p + 64'sd536870912;
            return PROD_W'(p >>> 30);
        end
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [PROD_W:0] v);
        logic signed [PROD_W+1:0] t;
        logic signed [PROD_W+1:0] q;
        begin
            t = (PROD_W+2)'(v) + (PROD_W+2)'(32768);
            q = t >>> 16;
            if (q > (PROD_W+2)'(16384))
            begin
                q = (PROD_W+2)'(16384);
            end
            if (q < -(PROD_W+2)'(16384))
            begin
                q = -(PROD_W+2)'(16384);
            end
            return 16'(q);
        end
    endfunction

    logic [NST-1:0] vld_reg;
    logic [NST:0]   vld_in;
    logic [NST:0]   rdy;
    logic           yaw_only_reg;

    assign vld_in = {vld_reg, in_valid};
    assign rdy[NST] = out_ready;
    assign in_ready = rdy[0];
    assign out_valid = vld_reg[NST-1];
    assign cfg_ready = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < NST; gi++)
        begin : g_rdy
            assign rdy[gi] = !vld_reg[gi] || rdy[gi+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            yaw_only_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                yaw_only_reg <= cfg_data;
            end
        end
    end

    // Squares and scaled numerators.
    logic signed [31:0] sq_xx;
    logic signed [31:0] sq_yy;
    logic signed [31:0] sq_zz;
    logic [31:0]        sxz_reg;
    logic [31:0]        syz_reg;
    carry_t             sq_c_reg;

    assign sq_xx = in_data.acc_x * in_data.acc_x;
    assign sq_yy = in_data.acc_y * in_data.acc_y;
    assign sq_zz = in_data.acc_z * in_data.acc_z;

    always_ff @(posedge clk)
    begin
        if (rdy[S_SQ])
        begin
            sxz_reg <= $unsigned(sq_xx) + $unsigned(sq_zz);
            syz_reg <= $unsigned(sq_yy) + $unsigned(sq_zz);
            sq_c_reg.num_r <= {in_data.acc_y, 14'b0};
            sq_c_reg.num_p <= {in_data.acc_x, 14'b0};
            sq_c_reg.mag_x <= {in_data.mag_x, 14'b0};
            sq_c_reg.mag_y <= {in_data.mag_y, 14'b0};
            sq_c_reg.yo <= yaw_only_reg;
        end
    end

    // Square roots, one result bit per stage.
    sqs_t   rt_r_reg [RT_W];
    sqs_t   rt_p_reg [RT_W];
    carry_t rt_c_reg [RT_W];

    generate
        for (gi = 0; gi < RT_W; gi++)
        begin : g_rt
            sqs_t   src_r;
            sqs_t   src_p;
            carry_t src_c;
            if (gi == 0)
            begin : g_first
                assign src_r = '{rem: SQ_W'({sxz_reg, 28'b0}), root: '0};
                assign src_p = '{rem: SQ_W'({syz_reg, 28'b0}), root: '0};
                assign src_c = sq_c_reg;
            end
            else
            begin : g_next
                assign src_r = rt_r_reg[gi-1];
                assign src_p = rt_p_reg[gi-1];
                assign src_c = rt_c_reg[gi-1];
            end
            always_ff @(posedge clk)
            begin
                if (rdy[S_RT+gi])
                begin
                    rt_r_reg[gi] <= sqrt_step(src_r, RT_W - 1 - gi);
                    rt_p_reg[gi] <= sqrt_step(src_p, RT_W - 1 - gi);
                    rt_c_reg[gi] <= src_c;
                end
            end
        end
    endgenerate

    // Quadrant correction; lanes are roll, pitch and yaw.
    cordic_t    pre_reg [3];
    logic [2:0] pre_zero_reg;
    logic       pre_yo_reg;
    carry_t     rt_last;
    logic signed [ANG_W-1:0] dr_s;
    logic signed [ANG_W-1:0] dp_s;
    logic signed [ANG_W-1:0] nr_s;
    logic signed [ANG_W-1:0] np_s;
    logic signed [ANG_W-1:0] mx_s;
    logic signed [ANG_W-1:0] my_s;

    assign rt_last = rt_c_reg[RT_W-1];
    assign dr_s = ANG_W'(rt_r_reg[RT_W-1].root);
    assign dp_s = ANG_W'(rt_p_reg[RT_W-1].root);
    assign nr_s = ANG_W'(rt_last.num_r);
    assign np_s = ANG_W'(rt_last.num_p);
    assign mx_s = ANG_W'(rt_last.mag_x);
    assign my_s = ANG_W'(rt_last.mag_y);

    always_ff @(posedge clk)
    begin
        if (rdy[S_PRE])
        begin
            pre_reg[0] <= prerot(nr_s, dr_s);
            pre_reg[1] <= prerot(np_s, dp_s);
            pre_reg[2] <= prerot(my_s, mx_s);
            pre_zero_reg[0] <= (nr_s == '0) && (dr_s == '0);
            pre_zero_reg[1] <= (np_s == '0) && (dp_s == '0);
            pre_zero_reg[2] <= (my_s == '0) && (mx_s == '0);
            pre_yo_reg <= rt_last.yo;
        end
    end

    // Vectoring iterations.
    cordic_t    vec_reg [NSTEP][3];
    logic [2:0] vz_reg [NSTEP];
    logic       vyo_reg [NSTEP];

    generate
        for (gi = 0; gi < NSTEP; gi++)
        begin : g_vec
            cordic_t    src [3];
            logic [2:0] src_z;
            logic       src_yo;
            if (gi == 0)
            begin : g_first
                assign src = pre_reg;
                assign src_z = pre_zero_reg;
                assign src_yo = pre_yo_reg;
            end
            else
            begin : g_next
                assign src = vec_reg[gi-1];
                assign src_z = vz_reg[gi-1];
                assign src_yo = vyo_reg[gi-1];
            end
            always_ff @(posedge clk)
            begin
                if (rdy[S_VEC+gi])
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        vec_reg[gi][l] <= vec_step(src[l], gi);
                    end
                    vz_reg[gi] <= src_z;
                    vyo_reg[gi] <= src_yo;
                end
            end
        end
    endgenerate

    // Half angles and start of rotation.
    cordic_t ang_reg [3];
    logic    ang_yo_reg;
    logic signed [ANG_W-1:0] ang_r;
    logic signed [ANG_W-1:0] ang_p;
    logic signed [ANG_W-1:0] ang_y;

    assign ang_r = vz_reg[NSTEP-1][0] ? '0 : vec_reg[NSTEP-1][0].z;
    assign ang_p = vz_reg[NSTEP-1][1] ? '0 : vec_reg[NSTEP-1][1].z;
    assign ang_y = vz_reg[NSTEP-1][2] ? '0 : -vec_reg[NSTEP-1][2].z;

    always_ff @(posedge clk)
    begin
        if (rdy[S_ANG])
        begin
            ang_reg[0] <= '{x: CORDIC_K, y: '0, z: ang_r >>> 1};
            ang_reg[1] <= '{x: CORDIC_K, y: '0, z: ang_p >>> 1};
            ang_reg[2] <= '{x: CORDIC_K, y: '0, z: ang_y >>> 1};
            ang_yo_reg <= vyo_reg[NSTEP-1];
        end
    end

    // Rotation iterations giving cosine and sine in Q30.
    cordic_t rot_reg [NSTEP][3];
    logic    ryo_reg [NSTEP];

    generate
        for (gi = 0; gi < NSTEP; gi++)
        begin : g_rot
            cordic_t src [3];
            logic    src_yo;
            if (gi == 0)
            begin : g_first
                assign src = ang_reg;
                assign src_yo = ang_yo_reg;
            end
            else
            begin : g_next
                assign src = rot_reg[gi-1];
                assign src_yo = ryo_reg[gi-1];
            end
            always_ff @(posedge clk)
            begin
                if (rdy[S_ROT+gi])
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        rot_reg[gi][l] <= rot_step(src[l], gi);
                    end
                    ryo_reg[gi] <= src_yo;
                end
            end
        end
    endgenerate

    // First products.
    logic signed [PROD_W-1:0] cr;
    logic signed [PROD_W-1:0] sr;
    logic signed [PROD_W-1:0] cp;
    logic signed [PROD_W-1:0] sp;
    logic signed [PROD_W-1:0] crcp_reg;
    logic signed [PROD_W-1:0] srsp_reg;
    logic signed [PROD_W-1:0] srcp_reg;
    logic signed [PROD_W-1:0] crsp_reg;
    logic signed [PROD_W-1:0] cy_reg;
    logic signed [PROD_W-1:0] sy_reg;

    assign cr = ryo_reg[NSTEP-1] ? ONE_Q30 : PROD_W'(rot_reg[NSTEP-1][0].x);
    assign sr = ryo_reg[NSTEP-1] ? '0 : PROD_W'(rot_reg[NSTEP-1][0].y);
    assign cp = ryo_reg[NSTEP-1] ? ONE_Q30 : PROD_W'(rot_reg[NSTEP-1][1].x);
    assign sp = ryo_reg[NSTEP-1] ? '0 : PROD_W'(rot_reg[NSTEP-1][1].y);

    always_ff @(posedge clk)
    begin
        if (rdy[S_MA])
        begin
            crcp_reg <= mulq(cr, cp);
            srsp_reg <= mulq(sr, sp);
            srcp_reg <= mulq(sr, cp);
            crsp_reg <= mulq(cr, sp);
            cy_reg <= PROD_W'(rot_reg[NSTEP-1][2].x);
            sy_reg <= PROD_W'(rot_reg[NSTEP-1][2].y);
        end
    end

    // Second products.
    logic signed [PROD_W-1:0] mb_reg [8];

    always_ff @(posedge clk)
    begin
        if (rdy[S_MB])
        begin
            mb_reg[0] <= mulq(crcp_reg, cy_reg);
            mb_reg[1] <= mulq(srsp_reg, sy_reg);
            mb_reg[2] <= mulq(srcp_reg, cy_reg);
            mb_reg[3] <= mulq(crsp_reg, sy_reg);
            mb_reg[4] <= mulq(crsp_reg, cy_reg);
            mb_reg[5] <= mulq(srcp_reg, sy_reg);
            mb_reg[6] <= mulq(crcp_reg, sy_reg);
            mb_reg[7] <= mulq(srsp_reg, cy_reg);
        end
    end

    // Differences, rounding and saturation into the output register.
    out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[S_OUT])
        begin
            out_reg.quat_w <= to_q14((PROD_W+1)'(mb_reg[0]) - (PROD_W+1)'(mb_reg[1]));
            out_reg.quat_x <= to_q14((PROD_W+1)'(mb_reg[2]) - (PROD_W+1)'(mb_reg[3]));
            out_reg.quat_y <= to_q14((PROD_W+1)'(mb_reg[4]) - (PROD_W+1)'(mb_reg[5]));
            out_reg.quat_z <= to_q14((PROD_W+1)'(mb_reg[6]) - (PROD_W+1)'(mb_reg[7]));
        end
    end

    assign out_data = out_reg;

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("Input stalled although the receiver is ready.");

    a_entry_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[S_SQ] |-> in_ready)
        else $error("Input stalled although the first stage is empty.");

    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[S_OUT] && vld_reg[S_MB] && !out_ready) |=> vld_reg[S_MB] && $stable(mb_reg[0]))
        else $error("Stage before the output register moved during a stall.");

    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.quat_w <= 16'sd16384 && out_data.quat_w >= -16'sd16384))
        else $error("Quaternion scalar part outside of one.");

endmodule

// File: verif/accel_mag_attitude_quaternion_checker.sv
// Checker that predicts each attitude quaternion and compares it with the block's output.
`timescale 1ns / 100ps
module accel_mag_attitude_quaternion_checker
    import amq_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic      cfg_data,
    output int        fail_count,
    output int        pending,
    output int        quat_count
);

    localparam longint QUARTER = 64'sd1073741824;
    localparam longint GAIN_K = 64'sd652032874;
    localparam longint UNIT_Q30 = 64'sd1073741824;

    logic      yaw_only_flag;
    out_item_t quat_queue[$];

    function automatic int num_steps();
        return (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    endfunction

    function automatic longint angle_step(int i);
        longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
            20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        return t[i];
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = QUARTER;
            end
            else
            begin
                t = x; x = -y; y = t; z = -QUARTER;
            end
        end
        for (int i = 0; i < num_steps(); i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += angle_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= angle_step(i);
            end
        end
        return z;
    endfunction

    task automatic rotate_unit(input longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = GAIN_K;
        y = 0;
        for (int i = 0; i < num_steps(); i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= angle_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += angle_step(i);
            end
        end
        c = x;
        s = y;
    endtask

    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] round_q14(longint v);
        longint q;
        q = (v + (64'sd1 << 15)) >>> 16;
        if (q > 16384)
            q = 16384;
        if (q < -16384)
            q = -16384;
        return 16'(q);
    endfunction

    task automatic predict_quaternion(input in_item_t d, output out_item_t q);
        longint ax, ay, az, mx, my;
        longint cr, sr, cp, sp, cy, sy;
        longint roll, pitch, yaw;
        ax = d.acc_x; ay = d.acc_y; az = d.acc_z; mx = d.mag_x; my = d.mag_y;
        if (yaw_only_flag)
        begin
            cr = UNIT_Q30; sr = 0; cp = UNIT_Q30; sp = 0;
        end
        else
        begin
            roll = vector_angle(ay * 16384, root_floor((ax * ax + az * az) << 28));
            pitch = vector_angle(ax * 16384, root_floor((ay * ay + az * az) << 28));
            rotate_unit(roll >>> 1, cr, sr);
            rotate_unit(pitch >>> 1, cp, sp);
        end
        yaw = -vector_angle(my * 16384, mx * 16384);
        rotate_unit(yaw >>> 1, cy, sy);
        q.quat_w = round_q14(mul_q30(mul_q30(cr, cp), cy) - mul_q30(mul_q30(sr, sp), sy));
        q.quat_x = round_q14(mul_q30(mul_q30(sr, cp), cy) - mul_q30(mul_q30(cr, sp), sy));
        q.quat_y = round_q14(mul_q30(mul_q30(cr, sp), cy) - mul_q30(mul_q30(sr, cp), sy));
        q.quat_z = round_q14(mul_q30(mul_q30(cr, cp), sy) - mul_q30(mul_q30(sr, sp), cy));
    endtask

    task automatic compare_field(string name, logic signed [15:0] e, logic signed [15:0] a);
        if (e !== a)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, e, a);
            fail_count++;
        end
    endtask

    assign pending = quat_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t q;
        if (!rst_n)
        begin
            yaw_only_flag <= 1'b0;
            quat_queue.delete();
            fail_count = 0;
            quat_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                quat_count++;
                if (quat_queue.size() == 0)
                begin
                    $error("quaternion item with none expected");
                    fail_count++;
                end
                else
                begin
                    q = quat_queue.pop_front();
                    compare_field("quat_w", q.quat_w, out_data.quat_w);
                    compare_field("quat_x", q.quat_x, out_data.quat_x);
                    compare_field("quat_y", q.quat_y, out_data.quat_y);
                    compare_field("quat_z", q.quat_z, out_data.quat_z);
                end
            end
            if (in_valid && in_ready)
            begin
                predict_quaternion(in_data, q);
                quat_queue.push_back(q);
            end
            if (cfg_valid && cfg_ready)
                yaw_only_flag <= cfg_data;
        end
    end

endmodule

// File: verif/accel_mag_attitude_quaternion_top_tb.sv
// Testbench top: drives sensor samples and mode writes, and gives the verdict.
`timescale 1ns / 100ps
module accel_mag_attitude_quaternion_top_tb;
    import amq_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    int        fail_count;
    int        pending;
    int        quat_count;
    int        send_idle;
    int        recv_idle;
    int        hold_cycles;

    accel_mag_attitude_quaternion_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    accel_mag_attitude_quaternion_checker quat_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .quat_count(quat_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic signed [15:0] sensor_value();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input in_item_t d);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        in_data <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80)
            @(negedge clk);
    endtask

    task automatic write_mode(input logic v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int n);
        in_item_t d;
        for (int i = 0; i < n; i++)
        begin
            d.acc_x = sensor_value();
            d.acc_y = sensor_value();
            d.acc_z = sensor_value();
            d.mag_x = sensor_value();
            d.mag_y = sensor_value();
            send_sample(d);
        end
    endtask

    initial
    begin
        in_item_t d;
        logic signed [15:0] edges[6] = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1,
            16'sd16384};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        out_ready = 1'b0;
        hold_cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Zero vectors, zero denominators, heading at 180 degrees and full-scale values.
        send_sample('{0, 0, 0, 0, 0});
        send_sample('{0, 0, 0, 16'sd100, 0});
        send_sample('{0, 0, 16'sd16384, -16'sd100, 0});
        send_sample('{0, 16'sd500, 0, 0, 16'sd100});
        send_sample('{16'sd500, 0, 0, 0, -16'sd100});
        send_sample('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_sample('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        send_sample('{16'sh8000, 16'sh7fff, 0, 16'sh8000, -16'sd1});
        for (int i = 0; i < 10; i++)
        begin
            d.acc_x = edges[$urandom_range(5)];
            d.acc_y = edges[$urandom_range(5)];
            d.acc_z = edges[$urandom_range(5)];
            d.mag_x = edges[$urandom_range(5)];
            d.mag_y = edges[$urandom_range(5)];
            send_sample(d);
        end
        write_mode(1'b1);
        send_sample('{16'sh7fff, 0, 0, -16'sd100, 0});
        send_sample('{0, 0, 0, 0, 0});
        send_sample('{16'sd3, 16'sd3, 16'sd3, 16'sd100, -16'sd100});
        write_mode(1'b0);

        send_idle = 30;
        recv_idle = 68;
        send_random(250);
        in_valid <= 1'b0;
        @(negedge clk);
        hold_cycles = 200;
        send_random(120);
        drain();
        send_random(30);
        write_mode(1'b1);
        send_idle = 68;
        recv_idle = 30;
        send_random(200);
        write_mode(1'b0);
        send_idle = 0;
        recv_idle = 0;
        send_random(200);
        drain();

        $display("Run covered %0d quaternion items in both modes, under sender and receiver stalls.",
            quat_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
